>>> sv/assert_macros.svh
// Assertion macros shared by the ring buffer modules.
// Clocked on clk, disabled while rst_n is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> sv/orsb_pkg.sv
// Shared constants and types for the overwriting sample ring buffer.
// No dependencies; used by orsb_ctrl, orsb_dp and the top level.
package orsb_pkg;

    localparam int DEPTH    = 1024;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SIZE_W   = 11;
    localparam int SAMPLE_W = 16;
    localparam int FUNC_W   = 2;
    localparam int PADDR_W  = 3;
    localparam int DATA_W   = 32;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // register index = paddr[2]
    localparam logic REG_SIZE_IN_USE = 1'b0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    typedef struct packed {
        logic do_op;     // item accepted this cycle
        logic load_out;  // move pending result into output register
    } orsb_cmd_t;

endpackage

>>> sv/orsb_ctrl.sv
// Controller for the ring buffer: request sequencing and output valid.
// Depends on orsb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module orsb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output orsb_pkg::orsb_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_take;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    always_comb
    begin
        cmd.do_op    = in_valid && (state_reg == ST_IDLE);
        cmd.load_out = (state_reg == ST_BUSY) && (!out_valid_reg || out_take);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.do_op)
                    state_next = ST_BUSY;
            end
            ST_BUSY:
            begin
                if (cmd.load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_CLK(a_accept_busy, (in_valid && !in_stall) |=> (state_reg == ST_BUSY), "accept did not enter busy")
    `ASSERT_CLK(a_rose_from_busy, $rose(out_valid_reg) |-> ($past(state_reg) == ST_BUSY), "result without request")
    `ASSERT_NEVER(a_load_overrun, cmd.load_out && out_valid_reg && out_stall, "result overwritten while stalled")

endmodule

>>> sv/orsb_dp.sv
// Datapath for the ring buffer: sample memory, pointers, count, size register
// and result registers. Depends on orsb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module orsb_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  orsb_pkg::orsb_cmd_t                  cmd,
    input  logic [orsb_pkg::FUNC_W-1:0]          func,
    input  logic signed [orsb_pkg::SAMPLE_W-1:0] sample_in,
    output logic signed [orsb_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                 sample_valid,
    output logic                                 overwrote,
    output logic [orsb_pkg::SIZE_W-1:0]          fill_count,
    input  logic                                 cfg_we,
    input  logic [orsb_pkg::SIZE_W-1:0]          cfg_wdata,
    output logic [orsb_pkg::SIZE_W-1:0]          size_in_use
);

    localparam int PTR_W = orsb_pkg::PTR_W;
    localparam int CNT_W = orsb_pkg::CNT_W;

    logic [orsb_pkg::SAMPLE_W-1:0] mem [orsb_pkg::DEPTH];

    logic [orsb_pkg::SIZE_W-1:0] size_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] hw_reg, hw_next;
    logic [CNT_W-1:0] eff_size;
    logic             wr_en, rd_en, dropped;
    logic             rd_hit;

    logic [orsb_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic                          pend_valid_reg;
    logic                          pend_hit_reg;
    logic                          pend_drop_reg;
    logic [CNT_W-1:0]              pend_count_reg;

    logic signed [orsb_pkg::SAMPLE_W-1:0] sample_out_reg;
    logic                                 sample_valid_reg;
    logic                                 overwrote_reg;
    logic [CNT_W-1:0]                     fill_count_reg;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p,
                                                     input logic [CNT_W-1:0] size);
        logic [CNT_W-1:0] n;
        n = CNT_W'(p) + 1'b1;
        return (n >= size) ? '0 : n[PTR_W-1:0];
    endfunction

    // zero acts as one, above depth acts as depth
    always_comb
    begin
        if (32'(size_reg) > orsb_pkg::DEPTH)
            eff_size = CNT_W'(orsb_pkg::DEPTH);
        else if (size_reg == '0)
            eff_size = CNT_W'(1);
        else
            eff_size = CNT_W'(size_reg);
    end

    // entries at or above the high-water mark were not written since the
    // last clear and read as zero
    assign rd_hit = (CNT_W'(rd_ptr_reg) < hw_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        hw_next     = hw_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        dropped     = 1'b0;
        if (cmd.do_op)
        begin
            unique case (func)
                orsb_pkg::FUNC_WRITE:
                begin
                    wr_en = 1'b1;
                    if (count_reg >= eff_size)
                    begin
                        // full (or size shrank): drop oldest, count holds
                        rd_ptr_next = ptr_advance(rd_ptr_reg, eff_size);
                        dropped     = 1'b1;
                    end
                    else
                        count_next = count_reg + 1'b1;
                    if (CNT_W'(wr_ptr_reg) >= hw_reg)
                        hw_next = CNT_W'(wr_ptr_reg) + 1'b1;
                    wr_ptr_next = ptr_advance(wr_ptr_reg, eff_size);
                end
                orsb_pkg::FUNC_READ:
                begin
                    if (count_reg != '0)
                    begin
                        rd_en       = 1'b1;
                        rd_ptr_next = ptr_advance(rd_ptr_reg, eff_size);
                        count_next  = count_reg - 1'b1;
                    end
                end
                orsb_pkg::FUNC_CLEAR:
                begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    count_next  = '0;
                    hw_next     = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= sample_in;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= orsb_pkg::SIZE_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            hw_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                size_reg <= cfg_wdata;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            hw_reg     <= hw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_op)
        begin
            pend_valid_reg <= rd_en;
            pend_hit_reg   <= rd_hit;
            pend_drop_reg  <= dropped;
            pend_count_reg <= count_next;
        end
        if (cmd.load_out)
        begin
            sample_out_reg   <= (pend_valid_reg && pend_hit_reg) ? rd_data_reg : '0;
            sample_valid_reg <= pend_valid_reg;
            overwrote_reg    <= pend_drop_reg;
            fill_count_reg   <= pend_count_reg;
        end
    end

    assign sample_out   = sample_out_reg;
    assign sample_valid = sample_valid_reg;
    assign overwrote    = overwrote_reg;
    assign fill_count   = orsb_pkg::SIZE_W'(fill_count_reg);
    assign size_in_use  = size_reg;

    `ASSERT_CLK(a_count_range, count_reg <= CNT_W'(orsb_pkg::DEPTH), "fill count above depth")
    `ASSERT_NEVER(a_rd_wr_same, rd_en && wr_en, "read and write in one request")
    `ASSERT_CLK(a_rd_nonempty, rd_en |-> (count_reg != '0), "read issued on empty buffer")

endmodule

>>> sv/overwriting_sample_ring_buffer_unit.sv
// Overwriting ring buffer of signed 16-bit samples, 1024 entries.
// A result is held in the pending and read-data registers, then moved into the output register once that is free.
// A new request is not taken until the previous result has moved into the output register.
// A request is taken while the previous result still waits in the output register.
// Reset: pointers, count and high-water mark zero, size_in_use 1024; memory is
// not cleared, entries not written since reset or the last clear read as zero.
module overwriting_sample_ring_buffer_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [orsb_pkg::FUNC_W-1:0]            func,
    input  logic signed [orsb_pkg::SAMPLE_W-1:0]   sample_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [orsb_pkg::SAMPLE_W-1:0]   sample_out,
    output logic                                   sample_valid,
    output logic                                   overwrote,
    output logic [orsb_pkg::SIZE_W-1:0]            fill_count,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [orsb_pkg::PADDR_W-1:0]           paddr,
    input  logic [orsb_pkg::DATA_W-1:0]            pwdata,
    output logic [orsb_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready
);

    orsb_pkg::orsb_cmd_t         cmd;
    logic                        cfg_we;
    logic [orsb_pkg::SIZE_W-1:0] size_in_use;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == orsb_pkg::REG_SIZE_IN_USE);

    always_comb
    begin
        unique case (paddr[2])
            orsb_pkg::REG_SIZE_IN_USE:
                prdata = orsb_pkg::DATA_W'(size_in_use);
            default:
                prdata = '0;
        endcase
    end

    orsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    orsb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .sample_in    (sample_in),
        .sample_out   (sample_out),
        .sample_valid (sample_valid),
        .overwrote    (overwrote),
        .fill_count   (fill_count),
        .cfg_we       (cfg_we),
        .cfg_wdata    (pwdata[orsb_pkg::SIZE_W-1:0]),
        .size_in_use  (size_in_use)
    );

endmodule

>>> tb/orsb_checker.sv
// Checker for the overwriting sample ring buffer: follows size_in_use over APB,
// predicts one result per accepted request and compares results in order.
// Depends on orsb_pkg.
module orsb_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [orsb_pkg::FUNC_W-1:0]          func,
    input  logic signed [orsb_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [orsb_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                 sample_valid,
    input  logic                                 overwrote,
    input  logic [orsb_pkg::SIZE_W-1:0]          fill_count,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [orsb_pkg::PADDR_W-1:0]         paddr,
    input  logic [orsb_pkg::DATA_W-1:0]          pwdata,
    input  logic [orsb_pkg::DATA_W-1:0]          prdata,
    output int                                   fail_count,
    output int                                   outstanding,
    output int                                   results_seen,
    output int                                   drops_seen,
    output int                                   valid_reads,
    output int                                   empty_reads
);
    import orsb_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       valid;
        logic                       dropped;
        logic [SIZE_W-1:0]          fill;
    } ring_result_t;

    logic [SAMPLE_W-1:0] ring_mem [DEPTH];
    int                  wr_ptr;
    int                  rd_ptr;
    int                  held;
    logic [SIZE_W-1:0]   size_reg;
    ring_result_t        ring_results_q[$];

    // size 0 behaves as 1, anything above DEPTH as DEPTH
    function automatic int wrap_point();
        if (size_reg == '0)
            return 1;
        if (size_reg > DEPTH)
            return DEPTH;
        return int'(size_reg);
    endfunction

    function automatic int next_slot(input int p, input int n);
        return (p + 1 >= n) ? 0 : p + 1;
    endfunction

    task automatic apply_ring_op(input logic [FUNC_W-1:0] f,
                                 input logic signed [SAMPLE_W-1:0] s);
        ring_result_t r;
        int           n;
        begin
            n = wrap_point();
            r = '0;
            case (f)
                FUNC_WRITE:
                begin
                    if (held >= n)
                    begin
                        rd_ptr    = next_slot(rd_ptr, n);
                        r.dropped = 1'b1;
                        drops_seen++;
                    end
                    else
                        held++;
                    ring_mem[wr_ptr % DEPTH] = s;
                    wr_ptr = next_slot(wr_ptr, n);
                end
                FUNC_READ:
                begin
                    if (held > 0)
                    begin
                        r.sample = ring_mem[rd_ptr % DEPTH];
                        r.valid  = 1'b1;
                        rd_ptr   = next_slot(rd_ptr, n);
                        held--;
                        valid_reads++;
                    end
                    else
                        empty_reads++;
                end
                FUNC_CLEAR:
                begin
                    wr_ptr = 0;
                    rd_ptr = 0;
                    held   = 0;
                    foreach (ring_mem[i])
                        ring_mem[i] = '0;
                end
                default: ;
            endcase
            r.fill = SIZE_W'(held);
            ring_results_q.push_back(r);
        end
    endtask

    initial
    begin
        foreach (ring_mem[i])
            ring_mem[i] = '0;
        wr_ptr       = 0;
        rd_ptr       = 0;
        held         = 0;
        size_reg     = SIZE_RESET;
        fail_count   = 0;
        outstanding  = 0;
        results_seen = 0;
        drops_seen   = 0;
        valid_reads  = 0;
        empty_reads  = 0;
    end

    always @(posedge clk)
    begin
        ring_result_t exp_r;
        if (rst_n)
        begin
            if (psel && penable && pready && paddr[2] == REG_SIZE_IN_USE)
            begin
                if (pwrite)
                    size_reg = pwdata[SIZE_W-1:0];
                else if (prdata !== DATA_W'(size_reg))
                begin
                    $display("%0t register read: expected %0d, got %0d",
                             $time, size_reg, prdata);
                    fail_count++;
                end
            end

            if (in_valid && !in_stall)
                apply_ring_op(func, sample_in);

            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (ring_results_q.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, got sample %0d fill %0d",
                             $time, sample_out, fill_count);
                    fail_count++;
                end
                else
                begin
                    exp_r = ring_results_q.pop_front();
                    if (sample_out !== exp_r.sample)
                    begin
                        $display("%0t sample_out: expected %0d, got %0d",
                                 $time, exp_r.sample, sample_out);
                        fail_count++;
                    end
                    if (sample_valid !== exp_r.valid)
                    begin
                        $display("%0t sample_valid: expected %0b, got %0b",
                                 $time, exp_r.valid, sample_valid);
                        fail_count++;
                    end
                    if (overwrote !== exp_r.dropped)
                    begin
                        $display("%0t overwrote: expected %0b, got %0b",
                                 $time, exp_r.dropped, overwrote);
                        fail_count++;
                    end
                    if (fill_count !== exp_r.fill)
                    begin
                        $display("%0t fill_count: expected %0d, got %0d",
                                 $time, exp_r.fill, fill_count);
                        fail_count++;
                    end
                end
            end
            outstanding = ring_results_q.size();
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top for overwriting_sample_ring_buffer_unit: clock, reset, request
// stimulus, result-side stalls, size register programming and the verdict.
// Depends on orsb_pkg, the DUT and orsb_checker.
module tb;
    import orsb_pkg::*;

    localparam logic [FUNC_W-1:0]  FUNC_UNUSED      = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_SIZE_IN_USE = {REG_SIZE_IN_USE, 2'b00};
    localparam int                 CYCLE_LIMIT      = 500000;
    localparam int                 DRAIN_CYCLES     = 8;
    localparam int                 NUM_PHASES       = 10;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [FUNC_W-1:0]          func;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       sample_valid;
    logic                       overwrote;
    logic [SIZE_W-1:0]          fill_count;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    int fail_count;
    int outstanding;
    int results_seen;
    int drops_seen;
    int valid_reads;
    int empty_reads;

    int cycle_count;
    int idle_pct;
    int stall_pct;
    int requests_sent;
    int size_settings;

    overwriting_sample_ring_buffer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .sample_in    (sample_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .sample_valid (sample_valid),
        .overwrote    (overwrote),
        .fill_count   (fill_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    orsb_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .sample_in    (sample_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .sample_valid (sample_valid),
        .overwrote    (overwrote),
        .fill_count   (fill_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .drops_seen   (drops_seen),
        .valid_reads  (valid_reads),
        .empty_reads  (empty_reads)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("** overwriting_sample_ring_buffer_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    // Leaves valid high after acceptance so back-to-back requests need no gap.
    task automatic send_request(input logic [FUNC_W-1:0] f,
                                input logic [SAMPLE_W-1:0] s);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid  <= 1'b1;
            func      <= f;
            sample_in <= s;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            requests_sent++;
        end
    endtask

    // drop valid and let the clock advance before polling, so the checker has counted the last accepted request
    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // write size_in_use, then read it straight back
    task automatic set_size(input logic [SIZE_W-1:0] v);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_SIZE_IN_USE;
            pwdata  <= DATA_W'(v);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            size_settings++;
        end
    endtask

    task automatic set_mode(input int m);
        begin
            case (m % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
        end
    endtask

    task automatic run_directed();
        begin
            // empty read, unused selector, extremes, clear
            send_request(FUNC_READ, 16'h1234);
            send_request(FUNC_UNUSED, 16'hFFFF);
            send_request(FUNC_WRITE, 16'h7FFF);
            send_request(FUNC_WRITE, 16'h8000);
            send_request(FUNC_READ, 16'h0000);
            send_request(FUNC_READ, 16'hFFFF);
            send_request(FUNC_WRITE, 16'hFFFF);
            send_request(FUNC_CLEAR, 16'h5A5A);
            send_request(FUNC_READ, 16'h0000);
            wait_idle();
            // size 0 acts as a single entry
            set_size(11'd0);
            send_request(FUNC_WRITE, 16'h0001);
            send_request(FUNC_WRITE, 16'hFFFE);
            send_request(FUNC_READ, 16'h0000);
            wait_idle();
            set_size(11'd2);
            send_request(FUNC_WRITE, 16'h0000);
            send_request(FUNC_WRITE, 16'h7FFE);
            send_request(FUNC_WRITE, 16'h8001);
            send_request(FUNC_READ, 16'h0000);
            send_request(FUNC_READ, 16'h0000);
            wait_idle();
            // fill beyond a later, smaller size; write pointer ends past the wrap
            set_size(11'd2047);
            send_request(FUNC_WRITE, 16'h1111);
            send_request(FUNC_WRITE, 16'h2222);
            send_request(FUNC_WRITE, 16'hCCCC);
            send_request(FUNC_WRITE, 16'hDDDD);
            wait_idle();
            set_size(11'd2);
            send_request(FUNC_WRITE, 16'h3333);
            send_request(FUNC_READ, 16'h0000);
            send_request(FUNC_READ, 16'h0000);
            send_request(FUNC_READ, 16'h0000);
            send_request(FUNC_READ, 16'h0000);
            wait_idle();
        end
    endtask

    task automatic run_phase(input int p);
        logic [SIZE_W-1:0] sz;
        logic [FUNC_W-1:0] f;
        int                n_items;
        int                fill_writes;
        int                wr_pct;
        int                r;
        begin
            fill_writes = 0;
            n_items     = 70;
            case (p)
                0: sz = 11'd1;
                1: sz = 11'd5;
                2: sz = 11'd0;
                3:
                begin
                    // wrap the full 1024-entry ring once
                    sz          = 11'd2047;
                    fill_writes = DEPTH + 2;
                    n_items     = DEPTH + 16;
                end
                4: sz = 11'd2;
                5: sz = SIZE_W'($urandom_range(3, 40));
                6: sz = 11'd1024;
                7: sz = SIZE_W'($urandom_range(1, 12));
                8: sz = SIZE_W'($urandom_range(1025, 2047));
                default: sz = SIZE_W'($urandom_range(1, 64));
            endcase
            set_mode(p);
            wr_pct = 45 + $urandom_range(30);
            // start from an empty ring so only written entries get read
            send_request(FUNC_CLEAR, SAMPLE_W'($urandom));
            wait_idle();
            set_size(sz);
            for (int k = 0; k < n_items; k++)
            begin
                r = $urandom_range(99);
                if (k < fill_writes || r < wr_pct)
                    f = FUNC_WRITE;
                else if (r < 96)
                    f = FUNC_READ;
                else if (r < 98)
                    f = FUNC_CLEAR;
                else
                    f = FUNC_UNUSED;
                send_request(f, SAMPLE_W'($urandom));
            end
            wait_idle();
        end
    endtask

    initial
    begin
        cycle_count   = 0;
        requests_sent = 0;
        size_settings = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        func      <= FUNC_WRITE;
        sample_in <= '0;
        out_stall <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(p);

        $display("Ran %0d requests (%0d results checked) over %0d size settings",
                 requests_sent, results_seen, size_settings);
        $display("with mixed idle/stall patterns: %0d overwrites, %0d reads, %0d empty reads",
                 drops_seen, valid_reads, empty_reads);
        if (fail_count == 0 && outstanding == 0)
            $display("** overwriting_sample_ring_buffer_unit: PASSED **");
        else
            $display("** overwriting_sample_ring_buffer_unit: FAILED **");
        $finish;
    end

endmodule
